@@ sv/mcd_pkg.sv @@
// Package for the MCU chroma downsampler: constants, codes, payload structs,
// the sequencer state type and the small lookup functions for ratios and reciprocals.
// Depends on nothing; mcu_chroma_downsampler_core imports it.
package mcd_pkg;

    // Geometry of the pixel store and of one block.
    localparam int MAX_FACTOR  = 4;
    localparam int BLOCK_SIDE  = 8;
    localparam int SAMPLES     = BLOCK_SIDE * BLOCK_SIDE;
    localparam int NUM_COMP    = 3;
    localparam int STORE_SIDE  = 32;
    localparam int STORE_DEPTH = STORE_SIDE * STORE_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PIX_W       = 24;

    // Area mean arithmetic: the sum of up to 16 bytes, times a rounded-up reciprocal.
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;

    typedef logic [2:0] t_factor;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_COLOR_MODE,
        CFG_LUMA_H,
        CFG_LUMA_V,
        CFG_CB_H,
        CFG_CB_V,
        CFG_CR_H,
        CFG_CR_V
    } t_cfg_idx;

    // Command and component codes.
    localparam logic       CMD_LOAD = 1'b0;
    localparam logic       CMD_EMIT = 1'b1;
    localparam logic [1:0] COMP_Y   = 2'd0;
    localparam logic [1:0] COMP_CB  = 2'd1;
    localparam logic [1:0] COMP_CR  = 2'd2;

    // One input transaction.
    typedef struct packed {
        logic       command;
        logic [4:0] pixel_row;
        logic [4:0] pixel_col;
        logic [7:0] luma;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic [1:0] want_component;
        logic [3:0] want_block;
    } t_in;

    // One result transaction.
    typedef struct packed {
        logic [1:0] out_component;
        logic [3:0] out_block;
        logic [5:0] sample_index;
        logic [7:0] sample_value;
        logic       last_sample;
        logic       request_error;
    } t_out;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_ERR,
        S_DIVB,
        S_READ,
        S_DRAIN,
        S_MUL,
        S_OUT
    } t_state;

    // Result of dividing a luma factor by a component factor.
    typedef struct packed {
        logic    ok;
        t_factor q;
    } t_ratio;

    function automatic logic f_factor_ok(input t_factor f);
        return (f >= t_factor'(1)) && (f <= t_factor'(MAX_FACTOR));
    endfunction

    // Whole quotient of two factors; ok is low when the division leaves a remainder
    // or either factor lies outside one to four.
    function automatic t_ratio f_ratio(input t_factor num, input t_factor den);
        t_ratio r;
        r.ok = 1'b1;
        case ({num, den})
            {3'd1, 3'd1}: r.q = 3'd1;
            {3'd2, 3'd1}: r.q = 3'd2;
            {3'd3, 3'd1}: r.q = 3'd3;
            {3'd4, 3'd1}: r.q = 3'd4;
            {3'd2, 3'd2}: r.q = 3'd1;
            {3'd4, 3'd2}: r.q = 3'd2;
            {3'd3, 3'd3}: r.q = 3'd1;
            {3'd4, 3'd4}: r.q = 3'd1;
            default: begin
                r.ok = 1'b0;
                r.q  = 3'd1;
            end
        endcase
        return r;
    endfunction

    // Reciprocal 2^16/d rounded up; exact truncated quotient for sums below 4096.
    function automatic logic [RECIP_W-1:0] f_recip(input logic [4:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd32768;
            5'd3:    r = 17'd21846;
            5'd4:    r = 17'd16384;
            5'd6:    r = 17'd10923;
            5'd8:    r = 17'd8192;
            5'd9:    r = 17'd7282;
            5'd12:   r = 17'd5462;
            5'd16:   r = 17'd4096;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

@@ sv/mcd_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; used for the pixel store of the MCU chroma downsampler.
module mcd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/mcu_chroma_downsampler_core.sv @@
// Top level of the MCU chroma downsampler: pixel store, request check and the
// sequencer that sums each averaging area and scales it by a reciprocal.
// Depends on mcd_pkg and mcd_ram.
//
// A load transaction leaves busy low, so pixels can be loaded every cycle while no
// emit is under way. An emit transaction raises busy until its last result is shown.
// An invalid request shows its one error result in the cycle right after acceptance,
// with busy high for that cycle only. A valid request first finds its block row and
// column by repeated subtraction of the h factor, then for each of the 64 samples
// reads the rx*ry pixels of the area one per cycle through the single store read
// port, then drains the read, does the reciprocal multiply and shows the result.
// Results are shown for exactly one cycle each, marked by o_res_valid, and cannot be
// held off.
// The pixel store is not cleared by reset; only written pixels may be requested.
module mcu_chroma_downsampler_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mcd_pkg::t_in  i_item,
    output logic          o_res_valid,
    output mcd_pkg::t_out o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [2:0]    i_cfg_data
);

    import mcd_pkg::*;

    // Configuration registers.
    logic    r_color_mode;
    t_factor r_luma_h, r_luma_v, r_cb_h, r_cb_v, r_cr_h, r_cr_v;

    // Sequencer state and request context.
    t_state             r_state, n_state;
    logic [1:0]         r_comp, n_comp;
    logic [3:0]         r_blk, n_blk;
    t_factor            r_ch, n_ch;
    t_factor            r_rx, n_rx;
    t_factor            r_ry, n_ry;
    logic [RECIP_W-1:0] r_recip, n_recip;
    logic [3:0]         r_rem, n_rem;
    logic [1:0]         r_br, n_br;
    logic [1:0]         r_bc, n_bc;
    logic [5:0]         r_s, n_s;
    logic [1:0]         r_dy, n_dy;
    logic [1:0]         r_dx, n_dx;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_rd_pend, n_rd_pend;
    logic [PROD_W-1:0]  r_prod, n_prod;

    // Store ports.
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [PIX_W-1:0]  ram_wdata, ram_rdata;

    // Request check terms.
    logic       accept;
    t_factor    req_ch, req_cv;
    t_ratio     ratio_h, ratio_v;
    logic [5:0] blk_count;
    logic       req_ok;
    logic [4:0] area;

    // Address and accumulate terms.
    logic [4:0] row_base, col_base;
    logic [7:0] row_prod, col_prod;
    logic [4:0] row_addr, col_addr;
    logic [7:0] rd_byte;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= 1'b1;
            r_luma_h     <= 3'd1;
            r_luma_v     <= 3'd1;
            r_cb_h       <= 3'd1;
            r_cb_v       <= 3'd1;
            r_cr_h       <= 3'd1;
            r_cr_v       <= 3'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_COLOR_MODE: r_color_mode <= i_cfg_data[0];
                CFG_LUMA_H:     r_luma_h     <= i_cfg_data;
                CFG_LUMA_V:     r_luma_v     <= i_cfg_data;
                CFG_CB_H:       r_cb_h       <= i_cfg_data;
                CFG_CB_V:       r_cb_v       <= i_cfg_data;
                CFG_CR_H:       r_cr_h       <= i_cfg_data;
                CFG_CR_V:       r_cr_v       <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Factors of the requested component and the validity of the request.
    always_comb begin
        case (i_item.want_component)
            COMP_Y: begin
                req_ch = r_luma_h;
                req_cv = r_luma_v;
            end
            COMP_CB: begin
                req_ch = r_cb_h;
                req_cv = r_cb_v;
            end
            default: begin
                req_ch = r_cr_h;
                req_cv = r_cr_v;
            end
        endcase
        ratio_h   = f_ratio(r_luma_h, req_ch);
        ratio_v   = f_ratio(r_luma_v, req_cv);
        blk_count = {3'b000, req_ch} * {3'b000, req_cv};
        area      = 5'({2'b00, ratio_h.q} * {2'b00, ratio_v.q});
        req_ok    = (i_item.want_component != 2'd3)
                 && !(i_item.want_component != COMP_Y && !r_color_mode)
                 && f_factor_ok(r_luma_h) && f_factor_ok(r_luma_v)
                 && f_factor_ok(req_ch) && f_factor_ok(req_cv)
                 && ratio_h.ok && ratio_v.ok
                 && ({2'b00, i_item.want_block} < blk_count);
    end

    // Store address of the current area pixel; the store wraps at 32 rows and columns.
    always_comb begin
        row_base = {r_br, r_s[5:3]};
        col_base = {r_bc, r_s[2:0]};
        row_prod = {3'b000, row_base} * {5'b00000, r_ry};
        col_prod = {3'b000, col_base} * {5'b00000, r_rx};
        row_addr = row_prod[4:0] + {3'b000, r_dy};
        col_addr = col_prod[4:0] + {3'b000, r_dx};
    end

    // Component byte of the pixel that the store returns.
    always_comb begin
        case (r_comp)
            COMP_Y:  rd_byte = ram_rdata[23:16];
            COMP_CB: rd_byte = ram_rdata[15:8];
            default: rd_byte = ram_rdata[7:0];
        endcase
    end

    // Load path into the store.
    assign ram_we    = accept && (i_item.command == CMD_LOAD);
    assign ram_waddr = {i_item.pixel_row, i_item.pixel_col};
    assign ram_wdata = {i_item.luma, i_item.chroma_blue, i_item.chroma_red};
    assign ram_re    = (r_state == S_READ);
    assign ram_raddr = {row_addr, col_addr};

    mcd_ram #(
        .WIDTH(PIX_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Sequencer: next state, counters, accumulator and result.
    always_comb begin
        n_state   = r_state;
        n_comp    = r_comp;
        n_blk     = r_blk;
        n_ch      = r_ch;
        n_rx      = r_rx;
        n_ry      = r_ry;
        n_recip   = r_recip;
        n_rem     = r_rem;
        n_br      = r_br;
        n_bc      = r_bc;
        n_s       = r_s;
        n_dy      = r_dy;
        n_dx      = r_dx;
        n_sum     = r_sum;
        n_rd_pend = 1'b0;
        n_prod    = r_prod;

        // A read issued last cycle has its data now.
        if (r_rd_pend) begin
            n_sum = r_sum + {4'b0000, rd_byte};
        end

        case (r_state)
            S_IDLE: begin
                if (accept && (i_item.command == CMD_EMIT)) begin
                    n_comp  = i_item.want_component;
                    n_blk   = i_item.want_block;
                    n_ch    = req_ch;
                    n_rx    = ratio_h.q;
                    n_ry    = ratio_v.q;
                    n_recip = f_recip(area);
                    n_rem   = i_item.want_block;
                    n_br    = 2'd0;
                    n_state = req_ok ? S_DIVB : S_ERR;
                end
            end
            S_ERR: begin
                n_state = S_IDLE;
            end
            S_DIVB: begin
                // Block row and column by repeated subtraction of the h factor.
                if (r_rem >= {1'b0, r_ch}) begin
                    n_rem = r_rem - {1'b0, r_ch};
                    n_br  = r_br + 2'd1;
                end else begin
                    n_bc    = r_rem[1:0];
                    n_s     = 6'd0;
                    n_dy    = 2'd0;
                    n_dx    = 2'd0;
                    n_sum   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_rd_pend = 1'b1;
                if ({1'b0, r_dx} == r_rx - 3'd1) begin
                    n_dx = 2'd0;
                    if ({1'b0, r_dy} == r_ry - 3'd1) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_dy = r_dy + 2'd1;
                    end
                end else begin
                    n_dx = r_dx + 2'd1;
                end
            end
            S_DRAIN: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = {{RECIP_W{1'b0}}, r_sum} * {{SUM_W{1'b0}}, r_recip};
                n_state = S_OUT;
            end
            S_OUT: begin
                if (r_s == 6'(SAMPLES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_s     = r_s + 6'd1;
                    n_dy    = 2'd0;
                    n_dx    = 2'd0;
                    n_sum   = '0;
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= n_rd_pend;
        end
    end

    // Request context and datapath registers.
    always_ff @(posedge i_clk) begin
        r_comp  <= n_comp;
        r_blk   <= n_blk;
        r_ch    <= n_ch;
        r_rx    <= n_rx;
        r_ry    <= n_ry;
        r_recip <= n_recip;
        r_rem   <= n_rem;
        r_br    <= n_br;
        r_bc    <= n_bc;
        r_s     <= n_s;
        r_dy    <= n_dy;
        r_dx    <= n_dx;
        r_sum   <= n_sum;
        r_prod  <= n_prod;
    end

    // Result transaction: one sample, or the single error result.
    always_comb begin
        o_res_valid         = (r_state == S_OUT) || (r_state == S_ERR);
        o_res.out_component = r_comp;
        o_res.out_block     = r_blk;
        if (r_state == S_ERR) begin
            o_res.sample_index  = 6'd0;
            o_res.sample_value  = 8'd0;
            o_res.last_sample   = 1'b1;
            o_res.request_error = 1'b1;
        end else begin
            o_res.sample_index  = r_s;
            o_res.sample_value  = r_prod[RECIP_SHIFT +: 8];
            o_res.last_sample   = (r_s == 6'(SAMPLES - 1));
            o_res.request_error = 1'b0;
        end
    end

endmodule
